/* rtl/core/pvb_pkg.sv */
// Shared types and constants for the voxel binning block.
// No dependencies; every other file in rtl/core uses this package.
package pvb_pkg;

    localparam int CELL_COUNT_DEF = 4096;
    localparam int COORD_BITS     = 16;
    localparam int CFG_W          = 24;
    localparam int CFG_AW         = 3;
    // linear voxel index before the range check: 8 + 16 + 24 bit terms
    localparam int ID_W           = 25;
    // (coord - origin) * scale, both 17-bit signed
    localparam int T_W            = 2 * (COORD_BITS + 1);

    typedef enum logic [CFG_AW-1:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_ORIGIN_Z  = 3'd2,
        REG_SCALE_X   = 3'd3,
        REG_SCALE_Y   = 3'd4,
        REG_SCALE_Z   = 3'd5,
        REG_GRID_DIVS = 3'd6,
        REG_STAT_EN   = 3'd7
    } cfg_reg_t;

    localparam int STAT_LAST  = 0;
    localparam int STAT_MIN   = 1;
    localparam int STAT_MAX   = 2;
    localparam int STAT_COUNT = 3;
    localparam int STAT_SUM   = 4;
    localparam int STAT_MEAN  = 5;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
        logic signed [15:0] field_value;
        logic [11:0]        read_cell;
    } in_t;

    typedef struct packed {
        logic [11:0]        cell_index;
        logic [7:0]         occupancy;
        logic signed [15:0] recent_value;
        logic signed [15:0] min_value;
        logic signed [15:0] max_value;
        logic [15:0]        point_count;
        logic signed [31:0] value_sum;
        logic signed [15:0] value_mean;
    } out_t;

    typedef struct packed {
        logic [7:0]         occupancy;
        logic signed [15:0] recent_value;
        logic signed [15:0] min_value;
        logic signed [15:0] max_value;
        logic [15:0]        point_count;
        logic signed [31:0] value_sum;
    } entry_t;

    localparam entry_t ENTRY_DEFAULT = '{
        occupancy:    8'h00,
        recent_value: 16'h0000,
        min_value:    16'h7FFF,
        max_value:    16'h8000,
        point_count:  16'h0000,
        value_sum:    32'h0000_0000
    };

    typedef struct packed {
        logic load_in;
        logic mul_en;
        logic clamp_en;
        logic idx1_en;
        logic idx2_en;
        logic rd_en;
        logic upd_en;
        logic div_step;
        logic out_load;
        logic clr_step;
    } cmd_t;

    typedef struct packed {
        logic in_read;
        logic mul_last;
        logic clr_last;
        logic div_need;
        logic div_last;
        logic out_busy;
    } sts_t;

endpackage

/* rtl/core/pvb_store.sv */
// Voxel statistics memory: one write port, one registered read port.
// Depends on pvb_pkg for the entry type.
module pvb_store #(
    parameter int DEPTH = pvb_pkg::CELL_COUNT_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  pvb_pkg::entry_t  wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output pvb_pkg::entry_t  rdata
);

    pvb_pkg::entry_t mem [DEPTH];
    pvb_pkg::entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/pvb_ctrl.sv */
// Sequencer for the voxel binning block: clear pass, binning, update, mean.
// Depends on pvb_pkg for the command and status structs.
module pvb_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pvb_pkg::sts_t sts,
    output pvb_pkg::cmd_t cmd
);

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b00_0000_0001,
        ST_IDLE  = 10'b00_0000_0010,
        ST_MUL   = 10'b00_0000_0100,
        ST_CLAMP = 10'b00_0000_1000,
        ST_IDX1  = 10'b00_0001_0000,
        ST_IDX2  = 10'b00_0010_0000,
        ST_READ  = 10'b00_0100_0000,
        ST_UPD   = 10'b00_1000_0000,
        ST_DIV   = 10'b01_0000_0000,
        ST_OUT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = sts.in_read ? ST_READ : ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                if (sts.mul_last) begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                cmd.clamp_en = 1'b1;
                state_next   = ST_IDX1;
            end
            ST_IDX1: begin
                cmd.idx1_en = 1'b1;
                state_next  = ST_IDX2;
            end
            ST_IDX2: begin
                cmd.idx2_en = 1'b1;
                state_next  = ST_READ;
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd_en = 1'b1;
                state_next = sts.div_need ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

/* rtl/core/pvb_dp.sv */
// Datapath: config registers, binning arithmetic, voxel update, mean divider.
// Depends on pvb_pkg and instantiates pvb_store.
module pvb_dp #(
    parameter int CELL_COUNT = pvb_pkg::CELL_COUNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wen,
    input  logic [pvb_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [pvb_pkg::CFG_W-1:0]   cfg_wdata,
    input  pvb_pkg::in_t                s_data,
    output pvb_pkg::out_t               m_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    input  pvb_pkg::cmd_t               cmd,
    output pvb_pkg::sts_t               sts
);

    localparam int AW  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int T_W = pvb_pkg::T_W;
    localparam int IDW = pvb_pkg::ID_W;

    // configuration
    logic signed [15:0] org_reg [3];
    logic [15:0]        scl_reg [3];
    logic [23:0]        divs_reg;
    logic [5:0]         sten_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            scl_reg[0] <= 16'd256;
            scl_reg[1] <= 16'd256;
            scl_reg[2] <= 16'd256;
            divs_reg   <= 24'h010101;
            sten_reg   <= '0;
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                pvb_pkg::REG_ORIGIN_X:  org_reg[0] <= cfg_wdata[15:0];
                pvb_pkg::REG_ORIGIN_Y:  org_reg[1] <= cfg_wdata[15:0];
                pvb_pkg::REG_ORIGIN_Z:  org_reg[2] <= cfg_wdata[15:0];
                pvb_pkg::REG_SCALE_X:   scl_reg[0] <= cfg_wdata[15:0];
                pvb_pkg::REG_SCALE_Y:   scl_reg[1] <= cfg_wdata[15:0];
                pvb_pkg::REG_SCALE_Z:   scl_reg[2] <= cfg_wdata[15:0];
                pvb_pkg::REG_GRID_DIVS: divs_reg   <= cfg_wdata[23:0];
                pvb_pkg::REG_STAT_EN:   sten_reg   <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // zero divisions behave as one
    logic [7:0] dx, dy, dz;
    assign dx = (divs_reg[7:0]   == 8'd0) ? 8'd1 : divs_reg[7:0];
    assign dy = (divs_reg[15:8]  == 8'd0) ? 8'd1 : divs_reg[15:8];
    assign dz = (divs_reg[23:16] == 8'd0) ? 8'd1 : divs_reg[23:16];

    // input capture
    pvb_pkg::in_t in_reg;
    logic [1:0]   axis_reg;
    logic [IDW-1:0] id_reg;

    // shared multiplier, one axis a cycle
    logic signed [15:0] mul_coord;
    logic signed [16:0] mul_d;
    logic signed [T_W-1:0] mul_t;
    logic signed [T_W-1:0] t_reg [3];

    always_comb begin
        case (axis_reg)
            2'd0:    mul_coord = in_reg.coord_x;
            2'd1:    mul_coord = in_reg.coord_y;
            default: mul_coord = in_reg.coord_z;
        endcase
        mul_d = {mul_coord[15], mul_coord} - {org_reg[axis_reg][15], org_reg[axis_reg]};
        mul_t = T_W'(mul_d * $signed({1'b0, scl_reg[axis_reg]}));
    end

    // clamp to 0..div-1, report whether past the voxel centre; {above, index}
    function automatic logic [8:0] bin_fn(input logic signed [T_W-1:0] t,
                                          input logic [7:0] div);
        logic [7:0]            dm1;
        logic [7:0]            q;
        logic signed [T_W-1:0] thr;
        dm1 = div - 8'd1;
        if (t < 0) begin
            q = 8'd0;
        end else if (t[T_W-1:8] > (T_W-8)'(dm1)) begin
            q = dm1;
        end else begin
            q = t[15:8];
        end
        thr = $signed(T_W'({q, 8'h80}));
        return {(t > thr), q};
    endfunction

    logic [8:0] bx, by, bz;
    assign bx = bin_fn(t_reg[0], dx);
    assign by = bin_fn(t_reg[1], dy);
    assign bz = bin_fn(t_reg[2], dz);

    logic [7:0]  ix_reg, iy_reg, iz_reg, code_reg;
    logic [15:0] p1_reg, dxdy_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg   <= s_data;
            axis_reg <= 2'd0;
            if (s_data.req_type == pvb_pkg::REQ_READ) begin
                id_reg <= IDW'(s_data.read_cell);
            end
        end
        if (cmd.mul_en) begin
            t_reg[axis_reg] <= mul_t;
            axis_reg        <= axis_reg + 2'd1;
        end
        if (cmd.clamp_en) begin
            ix_reg   <= bx[7:0];
            iy_reg   <= by[7:0];
            iz_reg   <= bz[7:0];
            code_reg <= 8'd1 << {bz[8], by[8], bx[8]};
        end
        if (cmd.idx1_en) begin
            p1_reg   <= iy_reg * dx;
            dxdy_reg <= dx * dy;
        end
        if (cmd.idx2_en) begin
            id_reg <= IDW'(ix_reg) + IDW'(p1_reg) + IDW'(iz_reg * dxdy_reg);
        end
    end

    assign sts.in_read  = (s_data.req_type == pvb_pkg::REQ_READ);
    assign sts.mul_last = (axis_reg == 2'd2);

    // clearing pass counter
    logic [AW-1:0] clr_cnt_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end
    assign sts.clr_last = (clr_cnt_reg == AW'(CELL_COUNT - 1));

    // voxel store
    logic            id_ok;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    pvb_pkg::entry_t mem_wdata, rd_entry, new_entry, res_entry;

    assign id_ok = (id_reg < IDW'(CELL_COUNT));

    pvb_store #(.DEPTH(CELL_COUNT)) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (cmd.rd_en),
        .raddr (id_reg[AW-1:0]),
        .rdata (rd_entry)
    );

    logic signed [15:0] fv;
    logic signed [32:0] sum_ext;
    logic               is_ins;

    always_comb begin
        fv        = in_reg.field_value;
        is_ins    = (in_reg.req_type == pvb_pkg::REQ_INSERT);
        new_entry = rd_entry;
        new_entry.occupancy = rd_entry.occupancy | code_reg;
        if (sten_reg[pvb_pkg::STAT_LAST]) begin
            new_entry.recent_value = fv;
        end
        if (sten_reg[pvb_pkg::STAT_MIN] && (fv < rd_entry.min_value)) begin
            new_entry.min_value = fv;
        end
        if (sten_reg[pvb_pkg::STAT_MAX] && (fv > rd_entry.max_value)) begin
            new_entry.max_value = fv;
        end
        if ((sten_reg[pvb_pkg::STAT_COUNT] || sten_reg[pvb_pkg::STAT_MEAN])
            && (rd_entry.point_count != 16'hFFFF)) begin
            new_entry.point_count = rd_entry.point_count + 16'd1;
        end
        sum_ext = {rd_entry.value_sum[31], rd_entry.value_sum} + {{17{fv[15]}}, fv};
        if (sten_reg[pvb_pkg::STAT_SUM] || sten_reg[pvb_pkg::STAT_MEAN]) begin
            if (sum_ext[32] != sum_ext[31]) begin
                new_entry.value_sum = sum_ext[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                new_entry.value_sum = sum_ext[31:0];
            end
        end

        if (!id_ok) begin
            res_entry = pvb_pkg::ENTRY_DEFAULT;
        end else if (is_ins) begin
            res_entry = new_entry;
        end else begin
            res_entry = rd_entry;
        end

        mem_we    = cmd.clr_step || (cmd.upd_en && is_ins && id_ok);
        mem_waddr = cmd.clr_step ? clr_cnt_reg : id_reg[AW-1:0];
        mem_wdata = cmd.clr_step ? pvb_pkg::ENTRY_DEFAULT : new_entry;
    end

    assign sts.div_need = id_ok && sten_reg[pvb_pkg::STAT_MEAN]
                          && (res_entry.point_count != 16'd0);

    // restoring divider, one quotient bit a cycle: |sum| / count
    pvb_pkg::entry_t res_reg;
    logic            need_reg, neg_reg;
    logic [31:0]     quo_reg;
    logic [16:0]     rem_reg;
    logic [15:0]     den_reg;
    logic [4:0]      dcnt_reg;
    logic [16:0]     div_r;
    logic            div_ge;

    assign div_r  = {rem_reg[15:0], quo_reg[31]};
    assign div_ge = (div_r >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (cmd.upd_en) begin
            res_reg  <= res_entry;
            need_reg <= sts.div_need;
            neg_reg  <= res_entry.value_sum[31];
            quo_reg  <= res_entry.value_sum[31] ? (32'd0 - res_entry.value_sum)
                                                : res_entry.value_sum;
            rem_reg  <= '0;
            den_reg  <= res_entry.point_count;
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg  <= div_ge ? (div_r - {1'b0, den_reg}) : div_r;
            quo_reg  <= {quo_reg[30:0], div_ge};
            dcnt_reg <= dcnt_reg + 5'd1;
        end
    end
    assign sts.div_last = (dcnt_reg == 5'd31);

    logic signed [15:0] mean;
    always_comb begin
        if (!need_reg) begin
            mean = '0;
        end else if (neg_reg) begin
            mean = (quo_reg > 32'd32768) ? 16'h8000 : 16'(32'd0 - quo_reg);
        end else begin
            mean = (quo_reg > 32'd32767) ? 16'h7FFF : quo_reg[15:0];
        end
    end

    // output register
    pvb_pkg::out_t m_data_reg;
    logic          m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.cell_index   <= id_reg[11:0];
            m_data_reg.occupancy    <= res_reg.occupancy;
            m_data_reg.recent_value <= res_reg.recent_value;
            m_data_reg.min_value    <= res_reg.min_value;
            m_data_reg.max_value    <= res_reg.max_value;
            m_data_reg.point_count  <= res_reg.point_count;
            m_data_reg.value_sum    <= res_reg.value_sum;
            m_data_reg.value_mean   <= mean;
        end
    end

    assign sts.out_busy = m_valid_reg && !m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

endmodule

/* rtl/core/point_voxel_binning_octant_stats.sv */
// Voxel grid binning with per-voxel octant occupancy and value statistics.
// Top level; depends on pvb_pkg, pvb_ctrl and pvb_dp.
//
// After reset the block sweeps its voxel store back to defaults, one entry a
// cycle, with s_ready low; configuration writes are taken throughout. It then
// handles one beat at a time. An insert runs the shared axis multiplier for x,
// y and z, then clamp, the index states IDX1 and IDX2, store read,
// read-modify-write and output load before the next acceptance; a voxel read
// runs only store read, update and output load. When the mean is enabled and
// the voxel count is nonzero, a bit-serial divider runs after the update. Results sit in
// an output register, so the finished beat may wait on m_ready while the next
// request is accepted; the next output load waits until that beat is taken.
module point_voxel_binning_octant_stats #(
    parameter int CELL_COUNT = pvb_pkg::CELL_COUNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wen,
    input  logic [pvb_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [pvb_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  pvb_pkg::in_t                s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output pvb_pkg::out_t               m_data
);

    pvb_pkg::cmd_t cmd;
    pvb_pkg::sts_t sts;

    pvb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pvb_dp #(.CELL_COUNT(CELL_COUNT)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
